/* sv/rse_pkg.sv */
// shared types, constants and microprogram for the rpn stack evaluator
`default_nettype none

package rse_pkg;

  localparam int unsigned DataW            = 32;
  localparam int unsigned CharW            = 8;
  localparam int unsigned StatusW          = 2;
  localparam int unsigned StepW            = 5;
  localparam int unsigned STACK_DEPTH_DEF  = 16;

  localparam logic [CharW-1:0] CH_0     = 8'h30;
  localparam logic [CharW-1:0] CH_9     = 8'h39;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_STAR  = 8'h2A;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_EQ    = 8'h3D;

  typedef logic [StepW-1:0] step_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  // datapath actions
  typedef enum logic [3:0] {
    A_NOP,
    A_DIGIT,
    A_PUSH,
    A_RDB,
    A_RDA,
    A_LATA,
    A_ALU,
    A_DSTART,
    A_DRES,
    A_WRR,
    A_EMIT,
    A_FAIL_UNDER,
    A_FAIL_OVER,
    A_FAIL_DIVZ
  } act_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_NOVALID,
    C_DIGIT,
    C_NOTNUM,
    C_FULL,
    C_NOTOP,
    C_LT2,
    C_NOTDIV,
    C_BZERO,
    C_DBUSY,
    C_NOTEQ,
    C_EMPTY
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic is_digit;
    logic in_num;
    logic full;
    logic is_op;
    logic lt2;
    logic is_div;
    logic b_zero;
    logic div_busy;
    logic is_eq;
    logic empty;
    logic out_stall;
  } flags_t;

  typedef struct packed {
    act_e act;
    logic in_ready;
  } ctrl_t;

  // program addresses
  localparam step_t S_FETCH = 5'd0;
  localparam step_t S_CLASS = 5'd1;
  localparam step_t S_NUMCK = 5'd2;
  localparam step_t S_FULCK = 5'd3;
  localparam step_t S_PUSH  = 5'd4;
  localparam step_t S_OPS   = 5'd5;
  localparam step_t S_RDB   = 5'd6;
  localparam step_t S_RDA   = 5'd7;
  localparam step_t S_LATA  = 5'd8;
  localparam step_t S_ZCK   = 5'd9;
  localparam step_t S_DST   = 5'd10;
  localparam step_t S_DWT   = 5'd11;
  localparam step_t S_DRES  = 5'd12;
  localparam step_t S_ALU   = 5'd13;
  localparam step_t S_WRR   = 5'd14;
  localparam step_t S_EQ    = 5'd15;
  localparam step_t S_EQRD  = 5'd16;
  localparam step_t S_EMIT  = 5'd17;
  localparam step_t S_UNDER = 5'd18;
  localparam step_t S_OVER  = 5'd19;
  localparam step_t S_DIVZ  = 5'd20;
  localparam step_t S_DIGIT = 5'd21;

  function automatic uword_t rse_ucode(step_t step);
    uword_t w;
    w = '{act: A_NOP, cond: C_JUMP, target: S_FETCH, emit: 1'b0};
    case (step)
      S_FETCH: w = '{act: A_NOP,         cond: C_NOVALID, target: S_FETCH, emit: 1'b0};
      S_CLASS: w = '{act: A_NOP,         cond: C_DIGIT,   target: S_DIGIT, emit: 1'b0};
      S_NUMCK: w = '{act: A_NOP,         cond: C_NOTNUM,  target: S_OPS,   emit: 1'b0};
      S_FULCK: w = '{act: A_NOP,         cond: C_FULL,    target: S_OVER,  emit: 1'b0};
      S_PUSH:  w = '{act: A_PUSH,        cond: C_NEXT,    target: S_FETCH, emit: 1'b0};
      S_OPS:   w = '{act: A_NOP,         cond: C_NOTOP,   target: S_EQ,    emit: 1'b0};
      S_RDB:   w = '{act: A_RDB,         cond: C_LT2,     target: S_UNDER, emit: 1'b0};
      S_RDA:   w = '{act: A_RDA,         cond: C_NEXT,    target: S_FETCH, emit: 1'b0};
      S_LATA:  w = '{act: A_LATA,        cond: C_NOTDIV,  target: S_ALU,   emit: 1'b0};
      S_ZCK:   w = '{act: A_NOP,         cond: C_BZERO,   target: S_DIVZ,  emit: 1'b0};
      S_DST:   w = '{act: A_DSTART,      cond: C_NEXT,    target: S_FETCH, emit: 1'b0};
      S_DWT:   w = '{act: A_NOP,         cond: C_DBUSY,   target: S_DWT,   emit: 1'b0};
      S_DRES:  w = '{act: A_DRES,        cond: C_JUMP,    target: S_WRR,   emit: 1'b0};
      S_ALU:   w = '{act: A_ALU,         cond: C_NEXT,    target: S_FETCH, emit: 1'b0};
      S_WRR:   w = '{act: A_WRR,         cond: C_JUMP,    target: S_FETCH, emit: 1'b0};
      S_EQ:    w = '{act: A_NOP,         cond: C_NOTEQ,   target: S_FETCH, emit: 1'b0};
      S_EQRD:  w = '{act: A_RDB,         cond: C_EMPTY,   target: S_UNDER, emit: 1'b0};
      S_EMIT:  w = '{act: A_EMIT,        cond: C_JUMP,    target: S_FETCH, emit: 1'b1};
      S_UNDER: w = '{act: A_FAIL_UNDER,  cond: C_JUMP,    target: S_FETCH, emit: 1'b1};
      S_OVER:  w = '{act: A_FAIL_OVER,   cond: C_JUMP,    target: S_FETCH, emit: 1'b1};
      S_DIVZ:  w = '{act: A_FAIL_DIVZ,   cond: C_JUMP,    target: S_FETCH, emit: 1'b1};
      S_DIGIT: w = '{act: A_DIGIT,       cond: C_JUMP,    target: S_FETCH, emit: 1'b0};
      default: w = '{act: A_NOP,         cond: C_JUMP,    target: S_FETCH, emit: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* sv/rse_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module rse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/rse_div.sv */
// iterative signed divider, truncating toward zero, one quotient bit per cycle
`default_nettype none

module rse_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rse_pkg::DataW-1:0] dividend_i,
  input  wire logic [rse_pkg::DataW-1:0] divisor_i,
  output logic                           busy_o,
  output logic      [rse_pkg::DataW-1:0] quotient_o
);

  import rse_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [DataW:0]  shifted;
  logic [DataW:0]  trial;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    shifted = {rem_q, quo_q[DataW-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
      den_d  = divisor_i[DataW-1] ? (DataW'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      // restoring step on magnitudes
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

/* sv/rse_useq.sv */
// microprogram sequencer: step counter, control rom and jump logic
`default_nettype none

module rse_useq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rse_pkg::flags_t flags_i,
  output rse_pkg::ctrl_t       ctrl_o
);

  import rse_pkg::*;

  step_t  step_q, step_d;
  uword_t word;
  logic   stall;
  logic   take;

  assign word  = rse_ucode(step_q);
  // a result step waits while the output register is still full
  assign stall = word.emit & flags_i.out_stall;

  always_comb begin
    case (word.cond)
      C_NEXT:    take = 1'b0;
      C_JUMP:    take = 1'b1;
      C_NOVALID: take = !flags_i.in_valid;
      C_DIGIT:   take = flags_i.is_digit;
      C_NOTNUM:  take = !flags_i.in_num;
      C_FULL:    take = flags_i.full;
      C_NOTOP:   take = !flags_i.is_op;
      C_LT2:     take = flags_i.lt2;
      C_NOTDIV:  take = !flags_i.is_div;
      C_BZERO:   take = flags_i.b_zero;
      C_DBUSY:   take = flags_i.div_busy;
      C_NOTEQ:   take = !flags_i.is_eq;
      C_EMPTY:   take = flags_i.empty;
      default:   take = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (take) begin
      step_d = word.target;
    end else begin
      step_d = step_q + StepW'(1);
    end
  end

  always_comb begin
    ctrl_o.act      = stall ? A_NOP : word.act;
    ctrl_o.in_ready = (step_q == S_FETCH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

/* sv/rpn_stack_evaluator_core.sv */
// top level of the rpn stack evaluator: datapath, operand stack and sequencer
// Reverse Polish evaluator over signed 32-bit integers, fed one ASCII character
// per input transaction. Digits build a decimal number (wrapping at 32 bits);
// any other character first pushes a number in progress. + - * / pop two values
// and push the result, division truncating toward zero; '=' returns the top of
// stack with status ok and empties the stack. Underflow, overflow and divide by
// zero return value zero with the matching status and clear the stack; other
// characters produce nothing. A result transaction appears only for '=' or an
// error. Items are processed one at a time by a microcoded sequencer stepping
// through a small control rom; a division waits on the one-bit-per-cycle
// divider. The operand stack sits in a single-port-read ram, so the two
// operands are read on successive cycles.
// A finished result waits in the output register while the next character is
// taken; only a further result step stalls on a full output register.
`default_nettype none

module rpn_stack_evaluator_core #(
  parameter int unsigned STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // character input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [rse_pkg::CharW-1:0]   character_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [rse_pkg::DataW-1:0] value_o,
  output logic      [rse_pkg::StatusW-1:0] status_o
);

  import rse_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  flags_t flags;
  ctrl_t  ctrl;

  // item and operand registers
  logic [CharW-1:0] char_q;
  logic [DataW-1:0] acc_q, acc_d;
  logic             in_num_q, in_num_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] a_q, b_q, r_q;
  logic [DataW-1:0] alu_res;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] value_q, value_d;
  status_e          status_q, status_d;

  // stack memory ports
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;
  logic [CntW-1:0]  cnt_m1, cnt_m2;

  logic             div_start, div_busy;
  logic [DataW-1:0] div_quo;
  logic [DataW-1:0] digit_val;

  logic in_accept;
  logic out_accept;

  assign in_accept  = in_valid_i & ctrl.in_ready;
  assign out_accept = out_valid_q & out_ready_i;

  assign cnt_m1 = cnt_q - CntW'(1);
  assign cnt_m2 = cnt_q - CntW'(2);

  // character classes and stack status for the jump conditions
  always_comb begin
    flags.in_valid  = in_valid_i;
    flags.is_digit  = char_q inside {[CH_0:CH_9]};
    flags.in_num    = in_num_q;
    flags.full      = (cnt_q == CntW'(STACK_DEPTH));
    flags.is_op     = char_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    flags.lt2       = (cnt_q < CntW'(2));
    flags.is_div    = (char_q == CH_SLASH);
    flags.b_zero    = (b_q == '0);
    flags.div_busy  = div_busy;
    flags.is_eq     = (char_q == CH_EQ);
    flags.empty     = (cnt_q == '0);
    flags.out_stall = out_valid_q & !out_ready_i;
  end

  rse_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  rse_ram #(
    .WIDTH (DataW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign div_start = (ctrl.act == A_DSTART);

  rse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // stack port control: push writes at count, a result replaces the second entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];
    ram_wdata = acc_q;
    ram_re    = 1'b0;
    ram_raddr = cnt_m1[AddrW-1:0];
    case (ctrl.act)
      A_PUSH: begin
        ram_we = 1'b1;
      end
      A_WRR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[AddrW-1:0];
        ram_wdata = r_q;
      end
      A_RDB: begin
        ram_re = 1'b1;
      end
      A_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_m2[AddrW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign digit_val = DataW'(char_q - CH_0);

  // add, subtract or low half of the product
  always_comb begin
    case (char_q)
      CH_PLUS:  alu_res = a_q + b_q;
      CH_MINUS: alu_res = a_q - b_q;
      default:  alu_res = a_q * b_q;
    endcase
  end

  // datapath next-state
  always_comb begin
    acc_d       = acc_q;
    in_num_d    = in_num_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & !out_accept;
    value_d     = value_q;
    status_d    = status_q;
    case (ctrl.act)
      A_DIGIT: begin
        // times ten as two shifts and an add
        acc_d    = in_num_q ? ((acc_q << 3) + (acc_q << 1) + digit_val) : digit_val;
        in_num_d = 1'b1;
      end
      A_PUSH: begin
        cnt_d    = cnt_q + CntW'(1);
        in_num_d = 1'b0;
      end
      A_WRR: begin
        cnt_d = cnt_m1;
      end
      A_EMIT: begin
        out_valid_d = 1'b1;
        value_d     = ram_rdata;
        status_d    = ST_OK;
        cnt_d       = '0;
      end
      A_FAIL_UNDER: begin
        out_valid_d = 1'b1;
        value_d     = '0;
        status_d    = ST_UNDER;
        cnt_d       = '0;
      end
      A_FAIL_OVER: begin
        out_valid_d = 1'b1;
        value_d     = '0;
        status_d    = ST_OVER;
        cnt_d       = '0;
        in_num_d    = 1'b0;
      end
      A_FAIL_DIVZ: begin
        out_valid_d = 1'b1;
        value_d     = '0;
        status_d    = ST_DIVZ;
        cnt_d       = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      in_num_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      in_num_q    <= in_num_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= character_i;
    end
    if (ctrl.act == A_RDA) begin
      b_q <= ram_rdata;
    end
    if (ctrl.act == A_LATA) begin
      a_q <= ram_rdata;
    end
    if (ctrl.act == A_ALU) begin
      r_q <= alu_res;
    end else if (ctrl.act == A_DRES) begin
      r_q <= div_quo;
    end
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(value_q);
  assign status_o    = status_q;

endmodule

`default_nettype wire
